// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define UFCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UFCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ufct_pkg.sv =====
package ufct_pkg;

  localparam int MAX_NODES = 1024;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int NODE_W    = 16;
  localparam int WIDE_W    = NODE_W + 1;
  localparam int SIZE_W    = 11;
  localparam int CFG_CNT_W = 11;
  localparam int KIND_W    = 2;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;

  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UNION  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REINIT = 2'd2;

  localparam logic REG_NODE_BASE  = 1'b0;
  localparam logic REG_NODE_COUNT = 1'b1;

  localparam logic [NODE_W-1:0]    RST_BASE  = 16'd1;
  localparam logic [CFG_CNT_W-1:0] RST_COUNT = 11'd1024;

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] off;
  } range_res_t;

  function automatic logic [NODE_W-1:0] eff_base(input logic [NODE_W-1:0] base);
    return (base == '0) ? NODE_W'(1) : base;
  endfunction

  function automatic logic [CNT_W-1:0] eff_count(input logic [NODE_W-1:0] base,
                                                 input logic [CFG_CNT_W-1:0] cnt);
    logic [WIDE_W-1:0] room;
    logic [WIDE_W-1:0] c;
    room = {1'b1, {NODE_W{1'b0}}} - {1'b0, base};
    c    = WIDE_W'(cnt);
    if (c == '0) c = WIDE_W'(1);
    if (c > WIDE_W'(MAX_NODES)) c = WIDE_W'(MAX_NODES);
    if (c > room) c = room;
    return c[CNT_W-1:0];
  endfunction

endpackage

// ===== design/ufct_ram.sv =====
module ufct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ufct_range.sv =====
module ufct_range (
  input  logic [ufct_pkg::NODE_W-1:0] value,
  input  logic [ufct_pkg::NODE_W-1:0] base,
  input  logic [ufct_pkg::CNT_W-1:0]  cnt,
  output ufct_pkg::range_res_t        res
);

  logic [ufct_pkg::WIDE_W-1:0] diff;

  assign diff    = {1'b0, value} - {1'b0, base};
  assign res.ok  = !diff[ufct_pkg::NODE_W] &&
                   ({1'b0, diff[ufct_pkg::NODE_W-1:0]} < ufct_pkg::WIDE_W'(cnt));
  assign res.off = diff[ufct_pkg::ADDR_W-1:0];

endmodule

// ===== design/union_find_cluster_table.sv =====
// Channel   Direction  Handshake              Payload
// in_       in         start, busy            in_kind, in_node_a, in_node_b
// out_      out        out_valid (1 cycle)    out_cluster_id, out_cluster_size,
//                                             out_cluster_count, out_merged,
//                                             out_out_of_range
// cfg       in/out     psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// Strobe follows FA, FL, FS: a find starts there, a union first runs ULA, ULB, USA, USB,
// UDEC, reinitialize first sweeps the table. A merging union also scans node_count
// (clamped) label entries, one per cycle via the read port, drains the last rewrite,
// writes both sizes. After reset a MAX_NODES-entry sweep rebuilds the table (busy high).
// One request at a time: busy stays high from accept until out_valid.
// Results cannot be stalled; out_valid is a single-cycle strobe.
`include "assert_macros.svh"

module union_find_cluster_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [ufct_pkg::KIND_W-1:0]      in_kind,
  input  logic [ufct_pkg::NODE_W-1:0]      in_node_a,
  input  logic [ufct_pkg::NODE_W-1:0]      in_node_b,
  output logic                             out_valid,
  output logic [ufct_pkg::NODE_W-1:0]      out_cluster_id,
  output logic [ufct_pkg::SIZE_W-1:0]      out_cluster_size,
  output logic [ufct_pkg::CFG_CNT_W-1:0]   out_cluster_count,
  output logic                             out_merged,
  output logic                             out_out_of_range,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ufct_pkg::PADDR_W-1:0]     paddr,
  input  logic [ufct_pkg::DATA_W-1:0]      pwdata,
  output logic [ufct_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_ULA, S_ULB, S_USA, S_USB, S_UDEC,
    S_SCAN, S_SZTO, S_SZFROM, S_FA, S_FL, S_FS
  } state_t;

  localparam int AW = ufct_pkg::ADDR_W;
  localparam int CW = ufct_pkg::CNT_W;
  localparam int NW = ufct_pkg::NODE_W;
  localparam int SW = ufct_pkg::SIZE_W;
  localparam int KW = ufct_pkg::CFG_CNT_W;

  state_t                state_r, state_nxt;
  logic [NW-1:0]         base_r;
  logic [KW-1:0]         count_r;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         prev_r, prev_nxt;
  logic                  init_item_r, init_item_nxt;
  logic [NW-1:0]         sweep_base_r, sweep_base_nxt;
  logic [NW-1:0]         a_r, a_nxt, b_r, b_nxt;
  logic                  a_ok_r, a_ok_nxt, b_ok_r, b_ok_nxt;
  logic [NW-1:0]         la_r, la_nxt, lb_r, lb_nxt;
  logic                  la_ok_r, la_ok_nxt, lb_ok_r, lb_ok_nxt;
  logic [AW-1:0]         la_off_r, la_off_nxt, lb_off_r, lb_off_nxt;
  logic [SW-1:0]         sa_r, sa_nxt;
  logic [NW-1:0]         from_r, from_nxt, to_r, to_nxt;
  logic [AW-1:0]         from_off_r, from_off_nxt, to_off_r, to_off_nxt;
  logic [SW-1:0]         sum_r, sum_nxt;
  logic                  merged_r, merged_nxt;
  logic [KW-1:0]         clusters_r, clusters_nxt;
  logic [NW-1:0]         id_r, id_nxt;
  logic                  id_ok_r, id_ok_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [NW-1:0]         out_id_r, out_id_nxt;
  logic [SW-1:0]         out_size_r, out_size_nxt;
  logic [KW-1:0]         out_count_r, out_count_nxt;
  logic                  out_merged_r, out_merged_nxt;
  logic                  out_oor_r, out_oor_nxt;

  logic [NW-1:0]         eff_base_w;
  logic [CW-1:0]         eff_cnt_w;
  logic [NW-1:0]         rng_in;
  ufct_pkg::range_res_t  rng;
  logic [NW-1:0]         id_w;
  logic [SW-1:0]         sb_w;
  logic [SW:0]           sum_w;

  logic                  lbl_we;
  logic [AW-1:0]         lbl_waddr, lbl_raddr;
  logic [NW-1:0]         lbl_wdata, lbl_rdata;
  logic                  sz_we;
  logic [AW-1:0]         sz_waddr, sz_raddr;
  logic [SW-1:0]         sz_wdata, sz_rdata;
  logic                  cfg_wr;

  assign eff_base_w = ufct_pkg::eff_base(base_r);
  assign eff_cnt_w  = ufct_pkg::eff_count(eff_base_w, count_r);

  ufct_range u_range (
    .value (rng_in),
    .base  (eff_base_w),
    .cnt   (eff_cnt_w),
    .res   (rng)
  );

  ufct_ram #(.WIDTH(NW), .DEPTH(ufct_pkg::MAX_NODES)) u_label_ram (
    .clk   (clk),
    .we    (lbl_we),
    .waddr (lbl_waddr),
    .wdata (lbl_wdata),
    .raddr (lbl_raddr),
    .rdata (lbl_rdata)
  );

  ufct_ram #(.WIDTH(SW), .DEPTH(ufct_pkg::MAX_NODES)) u_size_ram (
    .clk   (clk),
    .we    (sz_we),
    .waddr (sz_waddr),
    .wdata (sz_wdata),
    .raddr (sz_raddr),
    .rdata (sz_rdata)
  );

  assign id_w  = a_ok_r ? lbl_rdata : '0;
  assign sb_w  = lb_ok_r ? sz_rdata : '0;
  assign sum_w = {1'b0, sa_r} + {1'b0, sb_w};

  always_comb begin
    unique case (state_r)
      S_ULB:   rng_in = b_r;
      S_USA:   rng_in = la_r;
      S_USB:   rng_in = lb_r;
      S_FL:    rng_in = id_w;
      default: rng_in = a_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    prev_nxt       = prev_r;
    init_item_nxt  = init_item_r;
    sweep_base_nxt = sweep_base_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    a_ok_nxt       = a_ok_r;
    b_ok_nxt       = b_ok_r;
    la_nxt         = la_r;
    lb_nxt         = lb_r;
    la_ok_nxt      = la_ok_r;
    lb_ok_nxt      = lb_ok_r;
    la_off_nxt     = la_off_r;
    lb_off_nxt     = lb_off_r;
    sa_nxt         = sa_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    from_off_nxt   = from_off_r;
    to_off_nxt     = to_off_r;
    sum_nxt        = sum_r;
    merged_nxt     = merged_r;
    clusters_nxt   = clusters_r;
    id_nxt         = id_r;
    id_ok_nxt      = id_ok_r;
    out_valid_nxt  = 1'b0;
    out_id_nxt     = out_id_r;
    out_size_nxt   = out_size_r;
    out_count_nxt  = out_count_r;
    out_merged_nxt = out_merged_r;
    out_oor_nxt    = out_oor_r;
    lbl_we         = 1'b0;
    lbl_waddr      = idx_r[AW-1:0];
    lbl_wdata      = sweep_base_r + NW'(idx_r);
    lbl_raddr      = rng.off;
    sz_we          = 1'b0;
    sz_waddr       = idx_r[AW-1:0];
    sz_wdata       = SW'(1);
    sz_raddr       = rng.off;

    unique case (state_r)
      S_SWEEP: begin
        lbl_we  = 1'b1;
        sz_we   = 1'b1;
        idx_nxt = idx_r + CW'(1);
        if (idx_r == CW'(ufct_pkg::MAX_NODES - 1)) begin
          state_nxt = init_item_r ? S_FA : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          a_nxt      = in_node_a;
          b_nxt      = in_node_b;
          b_ok_nxt   = 1'b1;
          merged_nxt = 1'b0;
          unique case (in_kind)
            ufct_pkg::KIND_REINIT: begin
              sweep_base_nxt = eff_base_w;
              clusters_nxt   = KW'(eff_cnt_w);
              idx_nxt        = '0;
              init_item_nxt  = 1'b1;
              state_nxt      = S_SWEEP;
            end
            ufct_pkg::KIND_UNION: state_nxt = S_ULA;
            default:              state_nxt = S_FA;
          endcase
        end
      end
      S_ULA: begin
        a_ok_nxt  = rng.ok;
        state_nxt = S_ULB;
      end
      S_ULB: begin
        b_ok_nxt  = rng.ok;
        la_nxt    = a_ok_r ? lbl_rdata : '0;
        state_nxt = S_USA;
      end
      S_USA: begin
        lb_nxt     = b_ok_r ? lbl_rdata : '0;
        la_ok_nxt  = rng.ok;
        la_off_nxt = rng.off;
        state_nxt  = S_USB;
      end
      S_USB: begin
        sa_nxt     = la_ok_r ? sz_rdata : '0;
        lb_ok_nxt  = rng.ok;
        lb_off_nxt = rng.off;
        state_nxt  = S_UDEC;
      end
      S_UDEC: begin
        sum_nxt  = sum_w[SW] ? ufct_pkg::SIZE_MAX : sum_w[SW-1:0];
        idx_nxt  = '0;
        pend_nxt = 1'b0;
        if ((la_r != lb_r) && (sa_r != '0) && (sb_w != '0)) begin
          merged_nxt = 1'b1;
          state_nxt  = S_SCAN;
          if (sa_r < sb_w) begin
            from_nxt     = la_r;
            to_nxt       = lb_r;
            from_off_nxt = la_off_r;
            to_off_nxt   = lb_off_r;
          end else begin
            from_nxt     = lb_r;
            to_nxt       = la_r;
            from_off_nxt = lb_off_r;
            to_off_nxt   = la_off_r;
          end
        end else begin
          state_nxt = S_FA;
        end
      end
      S_SCAN: begin
        // read entry idx, compare and rewrite it in the next cycle
        lbl_waddr = prev_r;
        lbl_wdata = to_r;
        lbl_we    = pend_r && (lbl_rdata == from_r);
        if (idx_r < eff_cnt_w) begin
          lbl_raddr = idx_r[AW-1:0];
          pend_nxt  = 1'b1;
          prev_nxt  = idx_r[AW-1:0];
          idx_nxt   = idx_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_SZTO;
          end
        end
      end
      S_SZTO: begin
        sz_we     = 1'b1;
        sz_waddr  = to_off_r;
        sz_wdata  = sum_r;
        state_nxt = S_SZFROM;
      end
      S_SZFROM: begin
        sz_we    = 1'b1;
        sz_waddr = from_off_r;
        sz_wdata = '0;
        if (clusters_r != '0) begin
          clusters_nxt = clusters_r - KW'(1);
        end
        state_nxt = S_FA;
      end
      S_FA: begin
        a_ok_nxt  = rng.ok;
        state_nxt = S_FL;
      end
      S_FL: begin
        id_nxt    = id_w;
        id_ok_nxt = rng.ok;
        state_nxt = S_FS;
      end
      S_FS: begin
        out_valid_nxt  = 1'b1;
        out_id_nxt     = id_r;
        out_size_nxt   = id_ok_r ? sz_rdata : '0;
        out_count_nxt  = clusters_r;
        out_merged_nxt = merged_r;
        out_oor_nxt    = !a_ok_r || !b_ok_r;
        init_item_nxt  = 1'b0;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      idx_r        <= '0;
      pend_r       <= 1'b0;
      init_item_r  <= 1'b0;
      sweep_base_r <= ufct_pkg::RST_BASE;
      clusters_r   <= KW'(ufct_pkg::eff_count(ufct_pkg::RST_BASE, ufct_pkg::RST_COUNT));
      base_r       <= ufct_pkg::RST_BASE;
      count_r      <= ufct_pkg::RST_COUNT;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      pend_r       <= pend_nxt;
      init_item_r  <= init_item_nxt;
      sweep_base_r <= sweep_base_nxt;
      clusters_r   <= clusters_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr) begin
        unique case (paddr[2])
          ufct_pkg::REG_NODE_BASE:  base_r  <= pwdata[NW-1:0];
          ufct_pkg::REG_NODE_COUNT: count_r <= pwdata[KW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_r       <= prev_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    a_ok_r       <= a_ok_nxt;
    b_ok_r       <= b_ok_nxt;
    la_r         <= la_nxt;
    lb_r         <= lb_nxt;
    la_ok_r      <= la_ok_nxt;
    lb_ok_r      <= lb_ok_nxt;
    la_off_r     <= la_off_nxt;
    lb_off_r     <= lb_off_nxt;
    sa_r         <= sa_nxt;
    from_r       <= from_nxt;
    to_r         <= to_nxt;
    from_off_r   <= from_off_nxt;
    to_off_r     <= to_off_nxt;
    sum_r        <= sum_nxt;
    merged_r     <= merged_nxt;
    id_r         <= id_nxt;
    id_ok_r      <= id_ok_nxt;
    out_id_r     <= out_id_nxt;
    out_size_r   <= out_size_nxt;
    out_count_r  <= out_count_nxt;
    out_merged_r <= out_merged_nxt;
    out_oor_r    <= out_oor_nxt;
  end

  always_comb begin
    unique case (paddr[2])
      ufct_pkg::REG_NODE_BASE:  prdata = ufct_pkg::DATA_W'(base_r);
      ufct_pkg::REG_NODE_COUNT: prdata = ufct_pkg::DATA_W'(count_r);
      default:                  prdata = '0;
    endcase
  end

  assign pready            = 1'b1;
  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_cluster_id    = out_id_r;
  assign out_cluster_size  = out_size_r;
  assign out_cluster_count = out_count_r;
  assign out_merged        = out_merged_r;
  assign out_out_of_range  = out_oor_r;

  `UFCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `UFCT_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `UFCT_ASSERT_NOW(a_merge_in_range, out_valid && out_merged, !out_out_of_range,
                   "merge reported with a node out of range")
  `UFCT_ASSERT_NOW(a_merge_size, out_valid && out_merged, out_cluster_size > SW'(1),
                   "merged cluster smaller than two")

endmodule
